/* src/bcce_pkg.sv */
// shared types and constants of the byte capacity cache eviction unit
package bcce_pkg;
   localparam int ENTRIES   = 64;
   localparam int KEY_WIDTH = 32;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int CNT_W     = IDX_W + 1;
   localparam int CAP_W     = 40;
   localparam int SIZE_W    = 32;
   localparam int FREQ_W    = 32;
   localparam int RANK_W    = 48;
   localparam int REQ_W     = 104;
   localparam int RSP_W     = 48;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_TOUCH  = 2'd1;
   localparam logic [1:0] POL_LRU    = 2'd0;
   localparam logic [1:0] POL_LFU    = 2'd1;
   localparam logic [1:0] POL_SCORE  = 2'd2;
   localparam logic [1:0] POL_SLRU   = 2'd3;
   localparam logic       REG_CAP    = 1'b0;
   localparam logic       REG_POLICY = 1'b1;

   typedef struct packed {
      logic [KEY_WIDTH-1:0] key;
      logic [SIZE_W-1:0]    size;
      logic [FREQ_W-1:0]    freq;
      logic [RANK_W-1:0]    rank;
   } slot_word_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] idx;
      logic [SIZE_W-1:0] size;
   } victim_type;

   typedef struct packed {
      logic             sample;
      logic             first;
      logic [IDX_W-1:0] idx;
      logic             valid;
      logic             prot;
   } scan_type;
endpackage

/* src/bcce_slot_ram.sv */
// slot table memory holding key, size, frequency and rank per slot
module bcce_slot_ram (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [bcce_pkg::IDX_W-1:0] wr_addr,
   input  bcce_pkg::slot_word_type  wr_data,
   input  logic [bcce_pkg::IDX_W-1:0] rd_addr,
   output bcce_pkg::slot_word_type  rd_data
);
   import bcce_pkg::*;

   slot_word_type mem [ENTRIES];
   slot_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* src/bcce_rank_unit.sv */
// shared rank compare unit tracking the lowest-ranked valid slot of a scan
module bcce_rank_unit (
   input  logic                    clock,
   input  logic [1:0]              policy,
   input  bcce_pkg::scan_type      scan,
   input  bcce_pkg::slot_word_type word,
   output bcce_pkg::victim_type    best
);
   import bcce_pkg::*;

   logic [RANK_W:0] rank_cur;
   logic [RANK_W:0] best_rank_ff, best_rank_in;
   victim_type      best_ff, best_in;
   logic            take;

   always_comb begin
      if (policy == POL_LFU) begin
         rank_cur = {{(RANK_W+1-FREQ_W){1'b0}}, word.freq};
      end else if (policy == POL_SLRU && scan.prot) begin
         rank_cur = {1'b1, word.rank};
      end else begin
         rank_cur = {1'b0, word.rank};
      end
      take = scan.sample && scan.valid &&
             (scan.first || !best_ff.found || rank_cur < best_rank_ff);
      best_in      = best_ff;
      best_rank_in = best_rank_ff;
      if (take) begin
         best_in.found = 1'b1;
         best_in.idx   = scan.idx;
         best_in.size  = word.size;
         best_rank_in  = rank_cur;
      end else if (scan.sample && scan.first) begin
         best_in.found = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      best_ff      <= best_in;
      best_rank_ff <= best_rank_in;
   end

   assign best = best_ff;
endmodule

/* src/byte_capacity_cache_eviction_unit.sv */
// top level of the byte capacity cache eviction unit
// Usage:
//   req_* carries one request beat: cmd, key, item_bytes and score.
//   rsp_* returns one result beat per request: hit, evicted_bytes, stored.
//   csr_* writes the byte budget (index 0) or policy (index 1); always
//   ready; it must be written only while the block is idle (unenforced).
// Sequence:
//   a key scan through the slot memory read port, then a dispatch step;
//   a lookup then shows its result beat. a touch adds a slot update; an
//   insert adds check, place, free slot scan and write, each eviction a
//   victim scan through the shared rank compare unit, evict and check,
//   and a full slot table a victim scan and evict before the write. the
//   data sets the evictions. one request is in work at a time; req_tready
//   returns in the cycle after the result beat has been taken.
// Reset:
//   clears valid and protected flags, byte counts, sequence number,
//   budget, policy and control state; no memory clearing pass is needed.
// Stall:
//   the result beat is held in an output register until rsp_tready.
module byte_capacity_cache_eviction_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // cmd[1:0], key[33:2], item_bytes[65:34], score[97:66], zero fill
   input  logic [bcce_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // hit[0], evicted_bytes[40:1], stored[41], zero fill
   output logic [bcce_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_index,
   input  logic [bcce_pkg::CAP_W-1:0] csr_data
);
   import bcce_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_KEY   = 11'b00000000010,
      S_DISP  = 11'b00000000100,
      S_TOUCH = 11'b00000001000,
      S_CHK   = 11'b00000010000,
      S_VIC   = 11'b00000100000,
      S_EVICT = 11'b00001000000,
      S_PLACE = 11'b00010000000,
      S_FREE  = 11'b00100000000,
      S_WRITE = 11'b01000000000,
      S_RSP   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [1:0]        pol_ff, pol_in;
   logic [ENTRIES-1:0] valid_ff, valid_in, prot_ff, prot_in;
   logic [CAP_W-1:0]  used_ff, used_in, pused_ff, pused_in, before_ff, before_in;
   logic [RANK_W-1:0] seq_ff, seq_in, seq_inc;

   logic [1:0]           cmd_ff, cmd_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [SIZE_W-1:0]    bytes_ff, bytes_in;
   logic [31:0]          score_ff, score_in;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pipe_ff, pipe_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] hidx_ff, hidx_in;
   slot_word_type    hword_ff, hword_in;
   logic             ffound_ff, ffound_in;
   logic [IDX_W-1:0] tgt_ff, tgt_in;
   logic             vmode_ff, vmode_in;

   logic             rhit_ff, rhit_in, rst_ff, rst_in;
   logic [CAP_W-1:0] rev_ff, rev_in;

   slot_word_type rd_data, wr_data;
   logic          wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   scan_type      scan;
   victim_type    best;

   logic             scan_done;
   logic [RANK_W-1:0] rank_new;
   logic [CAP_W:0]   need;
   logic [CAP_W-1:0] vsize;
   logic [CAP_W+3:0] pmul5;
   logic [CAP_W+1:0] cap4;
   logic [CAP_W:0]   psum;

   bcce_slot_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bcce_rank_unit u_rank (
      .clock  (clock),
      .policy (pol_ff),
      .scan   (scan),
      .word   (rd_data),
      .best   (best)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = (state_ff == S_RSP);
   assign rsp_tdata  = {{(RSP_W-CAP_W-2){1'b0}}, rst_ff, rev_ff, rhit_ff};

   assign rd_addr   = cnt_ff[IDX_W-1:0];
   assign scan_done = (cnt_ff == CNT_W'(ENTRIES));
   assign seq_inc   = (seq_ff == '1) ? seq_ff : seq_ff + RANK_W'(1);
   assign vsize     = CAP_W'(best.size);
   assign need      = {1'b0, used_ff} + (CAP_W+1)'(bytes_ff);
   assign psum      = {1'b0, pused_ff} + (CAP_W+1)'(hword_ff.size);
   assign pmul5     = (CAP_W+4)'({psum, 2'b00}) + (CAP_W+4)'(psum);
   assign cap4      = {cap_ff, 2'b00};

   always_comb begin
      scan.sample = pipe_ff && (state_ff == S_VIC);
      scan.first  = (pidx_ff == '0);
      scan.idx    = pidx_ff;
      scan.valid  = valid_ff[pidx_ff];
      scan.prot   = prot_ff[pidx_ff];
   end

   always_comb begin
      state_in  = state_ff;
      cap_in    = cap_ff;
      pol_in    = pol_ff;
      valid_in  = valid_ff;
      prot_in   = prot_ff;
      used_in   = used_ff;
      pused_in  = pused_ff;
      before_in = before_ff;
      seq_in    = seq_ff;
      cmd_in    = cmd_ff;
      key_in    = key_ff;
      bytes_in  = bytes_ff;
      score_in  = score_ff;
      cnt_in    = cnt_ff;
      pipe_in   = 1'b0;
      pidx_in   = cnt_ff[IDX_W-1:0];
      found_in  = found_ff;
      hidx_in   = hidx_ff;
      hword_in  = hword_ff;
      ffound_in = ffound_ff;
      tgt_in    = tgt_ff;
      vmode_in  = vmode_ff;
      rhit_in   = rhit_ff;
      rev_in    = rev_ff;
      rst_in    = rst_ff;
      wr_en     = 1'b0;
      wr_addr   = tgt_ff;
      wr_data   = hword_ff;
      rank_new  = (pol_ff == POL_SCORE) ?
                  {{(RANK_W-32){1'b0}}, score_ff ^ 32'h8000_0000} : seq_ff;

      if (csr_valid && csr_ready) begin
         if (csr_index == REG_CAP) begin
            cap_in = csr_data;
         end else begin
            pol_in = csr_data[1:0];
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_tdata[1:0];
               key_in   = req_tdata[KEY_WIDTH+1:2];
               bytes_in = req_tdata[65:34];
               score_in = req_tdata[97:66];
               cnt_in   = '0;
               found_in = 1'b0;
               state_in = S_KEY;
            end
         end
         S_KEY: begin
            if (!scan_done) begin
               cnt_in  = cnt_ff + CNT_W'(1);
               pipe_in = 1'b1;
            end
            if (pipe_ff && !found_ff && valid_ff[pidx_ff] && rd_data.key == key_ff) begin
               found_in = 1'b1;
               hidx_in  = pidx_ff;
               hword_in = rd_data;
            end
            if (scan_done) begin
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            rhit_in   = found_ff;
            rev_in    = '0;
            rst_in    = 1'b0;
            before_in = used_ff;
            if (found_ff && (cmd_ff == CMD_TOUCH || cmd_ff == CMD_INSERT)) begin
               state_in = S_TOUCH;
            end else if (cmd_ff == CMD_INSERT) begin
               state_in = S_CHK;
            end else begin
               state_in = S_RSP;
            end
         end
         S_TOUCH: begin
            seq_in   = seq_inc;
            rank_new = (pol_ff == POL_SCORE) ?
                       {{(RANK_W-32){1'b0}}, score_ff ^ 32'h8000_0000} : seq_inc;
            wr_en    = 1'b1;
            wr_addr  = hidx_ff;
            wr_data  = hword_ff;
            wr_data.freq = (hword_ff.freq == '1) ? hword_ff.freq
                                                 : hword_ff.freq + FREQ_W'(1);
            wr_data.rank = rank_new;
            if (pol_ff == POL_SLRU && !prot_ff[hidx_ff] &&
                pmul5 <= (CAP_W+4)'(cap4)) begin
               prot_in[hidx_ff] = 1'b1;
               pused_in = psum[CAP_W-1:0];
            end
            state_in = S_RSP;
         end
         S_CHK: begin
            if (need > (CAP_W+1)'(cap_ff)) begin
               vmode_in = 1'b0;
               cnt_in   = '0;
               state_in = S_VIC;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_VIC: begin
            if (!scan_done) begin
               cnt_in  = cnt_ff + CNT_W'(1);
               pipe_in = 1'b1;
            end
            if (scan_done) begin
               state_in = S_EVICT;
            end
         end
         S_EVICT: begin
            if (!best.found) begin
               state_in = S_PLACE;
            end else begin
               used_in = (used_ff >= vsize) ? used_ff - vsize : '0;
               if (prot_ff[best.idx]) begin
                  pused_in = (pused_ff >= vsize) ? pused_ff - vsize : '0;
               end
               valid_in[best.idx] = 1'b0;
               prot_in[best.idx]  = 1'b0;
               tgt_in             = best.idx;
               state_in           = vmode_ff ? S_WRITE : S_CHK;
            end
         end
         S_PLACE: begin
            seq_in = seq_inc;
            if (CAP_W'(bytes_ff) > cap_ff) begin
               rev_in   = before_ff - used_ff;
               state_in = S_RSP;
            end else begin
               cnt_in    = '0;
               ffound_in = 1'b0;
               state_in  = S_FREE;
            end
         end
         S_FREE: begin
            if (!scan_done) begin
               cnt_in = cnt_ff + CNT_W'(1);
               if (!ffound_ff && !valid_ff[cnt_ff[IDX_W-1:0]]) begin
                  ffound_in = 1'b1;
                  tgt_in    = cnt_ff[IDX_W-1:0];
               end
            end else if (ffound_ff) begin
               state_in = S_WRITE;
            end else begin
               vmode_in = 1'b1;
               cnt_in   = '0;
               state_in = S_VIC;
            end
         end
         S_WRITE: begin
            wr_en        = 1'b1;
            wr_addr      = tgt_ff;
            wr_data.key  = key_ff;
            wr_data.size = bytes_ff;
            wr_data.freq = FREQ_W'(1);
            wr_data.rank = rank_new;
            rev_in       = before_ff - used_ff;
            used_in      = used_ff + CAP_W'(bytes_ff);
            valid_in[tgt_ff] = 1'b1;
            prot_in[tgt_ff]  = 1'b0;
            rst_in       = 1'b1;
            state_in     = S_RSP;
         end
         S_RSP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cap_ff   <= '0;
         pol_ff   <= POL_LRU;
         valid_ff <= '0;
         prot_ff  <= '0;
         used_ff  <= '0;
         pused_ff <= '0;
         seq_ff   <= '0;
         pipe_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cap_ff   <= cap_in;
         pol_ff   <= pol_in;
         valid_ff <= valid_in;
         prot_ff  <= prot_in;
         used_ff  <= used_in;
         pused_ff <= pused_in;
         seq_ff   <= seq_in;
         pipe_ff  <= pipe_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      before_ff <= before_in;
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      bytes_ff  <= bytes_in;
      score_ff  <= score_in;
      pidx_ff   <= pidx_in;
      found_ff  <= found_in;
      hidx_ff   <= hidx_in;
      hword_ff  <= hword_in;
      ffound_ff <= ffound_in;
      tgt_ff    <= tgt_in;
      vmode_ff  <= vmode_in;
      rhit_ff   <= rhit_in;
      rev_ff    <= rev_in;
      rst_ff    <= rst_in;
   end

   a_no_stored_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[41]))
      else $error("result marks both hit and stored");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("ready while a result waits");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("ready right after an accepted beat");
endmodule
